// ===== design/cwig_pkg.sv =====
`default_nettype none

package cwig_pkg;

	// Field widths of the configuration, the request and the result.
	localparam int DIM_W    = 9;
	localparam int STRIDE_W = 3;
	localparam int PAD_W    = 2;
	localparam int IDX_W    = 17;
	localparam int TAP_W    = 4;

	// Unsaturated grid size: up to 511 - 1 + 1 + 6 = 517.
	localparam int GRID_W = 10;

	// Signed tap position: up to 511 * 7 + 2, down to -3.
	localparam int POS_W = 13;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_ROWS = 2'd0,
		CFG_IN_COLS = 2'd1,
		CFG_STRIDE  = 2'd2,
		CFG_PADDING = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/cwig_grid_calc.sv =====
`default_nettype none

// Output grid size along one dimension, (dim - kernel + stride + 2*padding) / stride,
// floored at zero. Two register stages; the inputs are static configuration.
module cwig_grid_calc #(
	parameter int KERNEL = 3
) (
	input  wire                                clk,
	input  wire  [cwig_pkg::DIM_W-1:0]         dim,
	input  wire  [cwig_pkg::STRIDE_W-1:0]      stride_eff,
	input  wire  [cwig_pkg::PAD_W-1:0]         padding,
	output logic [cwig_pkg::GRID_W-1:0]        grid
);

	localparam int NUM_W = cwig_pkg::GRID_W + 1;
	localparam int RCP_W = 13;
	localparam int RCP_SH = 12;
	localparam int PROD_W = cwig_pkg::GRID_W + RCP_W;
	localparam logic signed [NUM_W-1:0] K_S = NUM_W'(KERNEL);

	// Reciprocal of the stride scaled by 4096, rounded up. Exact for numerators
	// below 682, which covers every reachable value.
	function automatic logic [RCP_W-1:0] recip(input logic [cwig_pkg::STRIDE_W-1:0] s);
		logic [RCP_W-1:0] m;
		case (s)
			3'd2:    m = 13'd2048;
			3'd3:    m = 13'd1366;
			3'd4:    m = 13'd1024;
			3'd5:    m = 13'd820;
			3'd6:    m = 13'd683;
			3'd7:    m = 13'd586;
			default: m = 13'd4096;
		endcase
		return m;
	endfunction

	logic signed [NUM_W-1:0]          num_d;
	logic signed [NUM_W-1:0]          num_q;
	logic [cwig_pkg::STRIDE_W-1:0]    stride_q;
	logic [PROD_W-1:0]                prod;
	logic [cwig_pkg::GRID_W-1:0]      grid_q;

	// Numerator of the grid formula.
	assign num_d = $signed({2'b00, dim}) + $signed({8'b0, stride_eff})
		+ $signed({8'b0, padding, 1'b0}) - K_S;

	always_ff @(posedge clk) begin
		num_q    <= num_d;
		stride_q <= stride_eff;
	end

	// Divide by the stride through a reciprocal multiply.
	assign prod = PROD_W'(num_q[cwig_pkg::GRID_W-1:0]) * PROD_W'(recip(stride_q));

	always_ff @(posedge clk) begin
		if (num_q <= 0) begin
			grid_q <= '0;
		end else begin
			grid_q <= prod[RCP_SH +: cwig_pkg::GRID_W];
		end
	end

	assign grid = grid_q;

endmodule

`default_nettype wire

// ===== design/conv_window_index_generator_core.sv =====
// Window tap index generator for a square-kernel convolution over a row-major plane.
// A request on the in channel (win_row, win_col) names one output window. For it
// the block sends KERNEL*KERNEL items on the out channel, tap row by tap row, each
// with the linear input index of the tap or -1 where the tap lies in the zero
// border, the tap number, a last_tap mark on the final tap, the output grid size
// and an outside_grid flag for windows beyond that grid.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Configuration is written on the cfg channel (cfg_ready is always high); the user
// must write it only while the block is idle, which the block does not enforce. After
// a write the grid size settles through the numerator and result registers of
// cwig_grid_calc. The first tap of a window passes the sequencer and stages 1, 2
// and 3 after its request is accepted. Unless the out channel stalls, one tap is
// issued per cycle; the tap sequencer takes the next request in the same cycle as
// the last tap of the current one. A stall on the out channel while an item is shown
// freezes the whole three-stage pipeline and the sequencer, and in_stall rises until
// the current window is fully issued. Reset returns the registers to 256 rows, 80
// columns, stride 1, padding 1 and empties the pipeline.

`default_nettype none

module conv_window_index_generator_core #(
	parameter int KERNEL  = 3,
	parameter int MAX_DIM = 256
) (
	input  wire                                    clk,
	input  wire                                    arst_n,

	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [cwig_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [cwig_pkg::DIM_W-1:0]             cfg_data,

	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire  [cwig_pkg::DIM_W-1:0]             win_row,
	input  wire  [cwig_pkg::DIM_W-1:0]             win_col,

	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic signed [cwig_pkg::IDX_W-1:0]      input_index,
	output logic [cwig_pkg::TAP_W-1:0]             tap_number,
	output logic                                   last_tap,
	output logic [cwig_pkg::DIM_W-1:0]             grid_rows,
	output logic [cwig_pkg::DIM_W-1:0]             grid_cols,
	output logic                                   outside_grid
);

	localparam int KW = (KERNEL > 1) ? $clog2(KERNEL) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(KERNEL - 1);
	localparam logic [12:0] MAX_V = 13'(MAX_DIM);
	localparam int DW = cwig_pkg::DIM_W;
	localparam int PW = cwig_pkg::POS_W;
	localparam int GW = cwig_pkg::GRID_W;
	localparam int PRD_W = 2 * DW;

	// Configuration registers.
	logic [DW-1:0]                   in_rows_q;
	logic [DW-1:0]                   in_cols_q;
	logic [cwig_pkg::STRIDE_W-1:0]   stride_q;
	logic [cwig_pkg::PAD_W-1:0]      padding_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rows_q <= 9'd256;
			in_cols_q <= 9'd80;
			stride_q  <= 3'd1;
			padding_q <= 2'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cwig_pkg::cfg_reg_t'(cfg_index))
				cwig_pkg::CFG_IN_ROWS: in_rows_q <= cfg_data;
				cwig_pkg::CFG_IN_COLS: in_cols_q <= cfg_data;
				cwig_pkg::CFG_STRIDE:  stride_q  <= cfg_data[cwig_pkg::STRIDE_W-1:0];
				cwig_pkg::CFG_PADDING: padding_q <= cfg_data[cwig_pkg::PAD_W-1:0];
			endcase
		end
	end

	// Effective dimensions and stride.
	logic [DW-1:0]                   rows_eff;
	logic [DW-1:0]                   cols_eff;
	logic [cwig_pkg::STRIDE_W-1:0]   s_eff;

	assign rows_eff = ({4'b0, in_rows_q} > MAX_V) ? MAX_V[DW-1:0] : in_rows_q;
	assign cols_eff = ({4'b0, in_cols_q} > MAX_V) ? MAX_V[DW-1:0] : in_cols_q;
	assign s_eff    = (stride_q == '0) ? 3'd1 : stride_q;

	// Grid size per dimension.
	logic [GW-1:0] grid_r;
	logic [GW-1:0] grid_c;

	cwig_grid_calc #(.KERNEL(KERNEL)) u_grid_rows (
		.clk        (clk),
		.dim        (rows_eff),
		.stride_eff (s_eff),
		.padding    (padding_q),
		.grid       (grid_r)
	);

	cwig_grid_calc #(.KERNEL(KERNEL)) u_grid_cols (
		.clk        (clk),
		.dim        (cols_eff),
		.stride_eff (s_eff),
		.padding    (padding_q),
		.grid       (grid_c)
	);

	// Pipeline control: the whole pipeline moves unless the output is stalled.
	logic valid_s1, valid_s2, valid_s3;
	logic adv;
	logic win_valid_q;
	logic [KW-1:0] kr_q, kc_q;
	logic [cwig_pkg::TAP_W-1:0] tap_q;
	logic win_last;
	logic tap_issue;
	logic in_acc;

	assign adv       = !(valid_s3 && out_stall);
	assign win_last  = (kr_q == K_LAST) && (kc_q == K_LAST);
	assign tap_issue = win_valid_q && adv;
	assign in_stall  = win_valid_q && !(adv && win_last);
	assign in_acc    = in_valid && !in_stall;

	// Window base positions, worked out when the request is taken.
	logic signed [PW-1:0] rbase_d, cbase_d;
	logic signed [PW-1:0] rbase_q, cbase_q;
	logic [DW-1:0]        wr_q, wc_q;

	assign rbase_d = $signed({1'b0, 12'(win_row) * 12'(s_eff)}) - $signed(PW'(padding_q));
	assign cbase_d = $signed({1'b0, 12'(win_col) * 12'(s_eff)}) - $signed(PW'(padding_q));

	// Tap sequencer: one tap per cycle while the pipeline advances, in tap-row then tap-column order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
			kr_q        <= '0;
			kc_q        <= '0;
			tap_q       <= '0;
		end else if (in_acc) begin
			win_valid_q <= 1'b1;
			kr_q        <= '0;
			kc_q        <= '0;
			tap_q       <= '0;
		end else if (tap_issue) begin
			if (win_last) begin
				win_valid_q <= 1'b0;
			end else if (kc_q == K_LAST) begin
				kc_q <= '0;
				kr_q <= kr_q + KW'(1);
			end else begin
				kc_q <= kc_q + KW'(1);
			end
			tap_q <= tap_q + cwig_pkg::TAP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rbase_q <= rbase_d;
			cbase_q <= cbase_d;
			wr_q    <= win_row;
			wc_q    <= win_col;
		end
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= win_valid_q;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: tap position.
	logic signed [PW-1:0]       r_s1, c_s1;
	logic [cwig_pkg::TAP_W-1:0] tap_s1;
	logic                       last_s1;
	logic [DW-1:0]              wr_s1, wc_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1    <= rbase_q + $signed(PW'(kr_q));
			c_s1    <= cbase_q + $signed(PW'(kc_q));
			tap_s1  <= tap_q;
			last_s1 <= win_last;
			wr_s1   <= wr_q;
			wc_s1   <= wc_q;
		end
	end

	// Stage 2: bounds check, row offset product and grid test.
	logic                       inb_d;
	logic                       inb_s2;
	logic [PRD_W-1:0]           prod_s2;
	logic [DW-1:0]              c_s2;
	logic [cwig_pkg::TAP_W-1:0] tap_s2;
	logic                       last_s2;
	logic                       outside_s2;
	logic [DW-1:0]              grid_rows_s2, grid_cols_s2;

	assign inb_d = (r_s1 >= 0) && (r_s1 < $signed(PW'(rows_eff)))
		&& (c_s1 >= 0) && (c_s1 < $signed(PW'(cols_eff)));

	always_ff @(posedge clk) begin
		if (adv) begin
			inb_s2       <= inb_d;
			prod_s2      <= PRD_W'(r_s1[DW-1:0]) * PRD_W'(cols_eff);
			c_s2         <= c_s1[DW-1:0];
			tap_s2       <= tap_s1;
			last_s2      <= last_s1;
			outside_s2   <= ({1'b0, wr_s1} >= grid_r) || ({1'b0, wc_s1} >= grid_c);
			grid_rows_s2 <= grid_r[GW-1] ? {DW{1'b1}} : grid_r[DW-1:0];
			grid_cols_s2 <= grid_c[GW-1] ? {DW{1'b1}} : grid_c[DW-1:0];
		end
	end

	// Stage 3: linear index, held in the output register.
	logic [PRD_W-1:0]                 sum_d;
	logic [cwig_pkg::IDX_W-1:0]       index_s3;
	logic [cwig_pkg::TAP_W-1:0]       tap_s3;
	logic                             last_s3;
	logic                             outside_s3;
	logic [DW-1:0]                    grid_rows_s3, grid_cols_s3;

	assign sum_d = prod_s2 + PRD_W'(c_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			index_s3     <= inb_s2 ? sum_d[cwig_pkg::IDX_W-1:0] : {cwig_pkg::IDX_W{1'b1}};
			tap_s3       <= tap_s2;
			last_s3      <= last_s2;
			outside_s3   <= outside_s2;
			grid_rows_s3 <= grid_rows_s2;
			grid_cols_s3 <= grid_cols_s2;
		end
	end

	assign out_valid    = valid_s3;
	assign input_index  = $signed(index_s3);
	assign tap_number   = tap_s3;
	assign last_tap     = last_s3;
	assign grid_rows    = grid_rows_s3;
	assign grid_cols    = grid_cols_s3;
	assign outside_grid = outside_s3;

endmodule

`default_nettype wire

// ===== design/cwig_checker.sv =====
`default_nettype none

module cwig_checker #(
	parameter int KERNEL = 3
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_stall,
	input wire                                 out_valid,
	input wire                                 out_stall,
	input wire signed [cwig_pkg::IDX_W-1:0]    input_index,
	input wire [cwig_pkg::TAP_W-1:0]           tap_number,
	input wire                                 last_tap,
	input wire [cwig_pkg::DIM_W-1:0]           grid_rows,
	input wire [cwig_pkg::DIM_W-1:0]           grid_cols,
	input wire                                 outside_grid
);

	localparam logic [cwig_pkg::TAP_W-1:0] TAP_LAST = cwig_pkg::TAP_W'(KERNEL * KERNEL - 1);

	// A stalled result item stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(input_index)
			&& $stable(tap_number) && $stable(last_tap))
		else $error("stalled result item changed");

	// The last mark sits on the final tap of the kernel.
	a_last_tap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_tap |-> tap_number == TAP_LAST)
		else $error("last_tap on a tap other than the final one");

	// Taps of one window follow without gaps and share the window's fields.
	a_tap_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_tap |=> out_valid
			&& tap_number == $past(tap_number) + 4'd1
			&& $stable(grid_rows) && $stable(grid_cols) && $stable(outside_grid))
		else $error("tap sequence of a window broken");

	// While the result side stays stalled, a pending window keeps the request side stalled.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && !last_tap && in_stall ##1 out_stall |-> in_stall)
		else $error("request taken while the current window is still pending");

endmodule

bind conv_window_index_generator_core cwig_checker #(.KERNEL(KERNEL)) u_cwig_checker (.*);

`default_nettype wire
